@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the circle raster generator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/crg_pkg.sv @@
// ---------------------------------------------------------------------------
// crg_pkg
// Types and constants shared by the circle raster generator modules.
// ---------------------------------------------------------------------------
package crg_pkg;

  localparam int unsigned CRG_COORD_WIDTH = 12;
  localparam int unsigned CRG_QUEUE_DEPTH = 4;

  // Added to the colour after each step: +1 - 0x10000 modulo 2^32.
  localparam logic [31:0] CRG_COLOUR_STEP = 32'h0000_0001 - 32'h0001_0000;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic active;
    logic emitting;
  } back_status_t;

endpackage

@@ src/crg_front.sv @@
// ---------------------------------------------------------------------------
// crg_front
// Input register stage: takes items, classifies them and feeds the queue.
// ---------------------------------------------------------------------------
module crg_front
  import crg_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CRG_COORD_WIDTH,
  parameter int unsigned IN_DATA_W   = ((3 * COORD_WIDTH + 31) + 7) / 8 * 8,
  parameter int unsigned CMD_W       = 3 * COORD_WIDTH + 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output logic [CMD_W-1:0]     cmd_data
);

  localparam int unsigned PAYLOAD_W = 3 * COORD_WIDTH + 31;

  logic                 valid_r, valid_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  cmd_kind_t            kind;
  logic                 take;

  // The item kind rides in tuser; the low 3*COORD_WIDTH+31 bits of tdata are carried unchanged.
  assign kind      = cmd_kind_t'(in_tuser);
  assign in_tready = !valid_r || cmd_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (take) begin
      valid_nxt = 1'b1;
      cmd_nxt   = {in_tdata[PAYLOAD_W-1:0], kind};
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

endmodule

@@ src/crg_queue.sv @@
// ---------------------------------------------------------------------------
// crg_queue
// Short command queue between the front stage and the pixel engine.
// ---------------------------------------------------------------------------
module crg_queue
  import crg_pkg::*;
#(
  parameter int unsigned WIDTH = 3 * CRG_COORD_WIDTH + 32,
  parameter int unsigned DEPTH = CRG_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = entry_r[rd_ptr_r];
  assign level    = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/crg_back.sv @@
// ---------------------------------------------------------------------------
// crg_back
// Pixel engine: holds the circle state and emits four mirrored pixels a step.
// ---------------------------------------------------------------------------
module crg_back
  import crg_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CRG_COORD_WIDTH,
  parameter int unsigned CMD_W       = 3 * COORD_WIDTH + 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [CMD_W-1:0]             cmd_data,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output logic signed [COORD_WIDTH+1:0] pix_x,
  output logic signed [COORD_WIDTH+1:0] pix_y,
  output logic [31:0]                  pix_colour,
  output logic                         pix_last,
  output logic                         pix_done,
  output back_status_t                 status
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned OW = CW + 1;  // signed offsets
  localparam int unsigned DW = CW + 4;  // signed decision term
  localparam int unsigned EW = CW + 6;  // intermediate error terms
  localparam int unsigned PW = CW + 2;  // pixel coordinates

  // Command unpacking.
  cmd_kind_t     c_kind;
  logic [CW-1:0] c_cx, c_cy;
  logic [CW-2:0] c_radius;
  logic [31:0]   c_colour;

  assign c_kind   = cmd_kind_t'(cmd_data[0]);
  assign c_cx     = cmd_data[CW:1];
  assign c_cy     = cmd_data[2*CW:CW+1];
  assign c_radius = cmd_data[3*CW-1:2*CW+1];
  assign c_colour = cmd_data[3*CW+31:3*CW];

  // Circle state.
  logic                 active_r, active_nxt;
  logic                 emitting_r, emitting_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic signed [OW-1:0] ox_r, ox_nxt;
  logic signed [OW-1:0] oy_r, oy_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic [CW-1:0]        cx_r, cx_nxt;
  logic [CW-1:0]        cy_r, cy_nxt;
  logic [31:0]          col_r, col_nxt;

  // Output register.
  logic                 ov_r, ov_nxt;
  logic signed [PW-1:0] opx_r, opx_nxt;
  logic signed [PW-1:0] opy_r, opy_nxt;
  logic [31:0]          ocol_r, ocol_nxt;
  logic                 olast_r, olast_nxt;
  logic                 odone_r, odone_nxt;

  // Decision rule, evaluated from the current point.
  logic signed [EW-1:0] xe, ye, de, err1, err2, x1, y1, d1;
  logic                 ends;

  always_comb begin
    xe   = {{(EW-OW){ox_r[OW-1]}}, ox_r};
    ye   = {{(EW-OW){oy_r[OW-1]}}, oy_r};
    de   = {{(EW-DW){d_r[DW-1]}}, d_r};
    err1 = ((de + ye) <<< 1) - EW'(1);
    err2 = ((de - xe) <<< 1) - EW'(1);
    x1   = xe;
    y1   = ye;
    if (de < 0 && err1 <= 0) begin
      x1 = xe + EW'(1);
      d1 = de + (x1 <<< 1) + EW'(1);
    end else if (de > 0 && err2 > 0) begin
      y1 = ye - EW'(1);
      d1 = de + EW'(1) - (y1 <<< 1);
    end else begin
      x1 = xe + EW'(1);
      y1 = ye - EW'(1);
      d1 = de + ((x1 - ye) <<< 1);
    end
    ends = y1 < 0;
  end

  // Mirrored pixel for a phase: bit 1 negates x, bit 0 negates y.
  logic signed [PW-1:0] cxp, cyp, oxp, oyp;
  logic [1:0]           sel;

  assign cxp = $signed({2'b00, cx_r});
  assign cyp = $signed({2'b00, cy_r});
  assign oxp = {{(PW-OW){ox_r[OW-1]}}, ox_r};
  assign oyp = {{(PW-OW){oy_r[OW-1]}}, oy_r};

  logic slot_free, pop, emit;

  assign slot_free = !ov_r || pix_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_ready = !emitting_r && (c_kind == CMD_START || !active_r || slot_free);
  // A step with a circle in progress emits its first pixel on the pop cycle.
  assign emit      = (emitting_r && slot_free) || (pop && c_kind == CMD_STEP && active_r);
  assign sel       = emitting_r ? phase_r : 2'd0;

  always_comb begin
    active_nxt   = active_r;
    emitting_nxt = emitting_r;
    phase_nxt    = phase_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    d_nxt        = d_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    col_nxt      = col_r;
    ov_nxt       = ov_r && !pix_ready;
    opx_nxt      = opx_r;
    opy_nxt      = opy_r;
    ocol_nxt     = ocol_r;
    olast_nxt    = olast_r;
    odone_nxt    = odone_r;

    if (pop && c_kind == CMD_START) begin
      cx_nxt     = c_cx;
      cy_nxt     = c_cy;
      ox_nxt     = '0;
      oy_nxt     = {2'b00, c_radius};
      d_nxt      = DW'(1) - {4'b0000, c_radius, 1'b0};
      col_nxt    = c_colour;
      active_nxt = 1'b1;
    end

    if (emit) begin
      ov_nxt    = 1'b1;
      opx_nxt   = sel[1] ? cxp - oxp : cxp + oxp;
      opy_nxt   = sel[0] ? cyp - oyp : cyp + oyp;
      ocol_nxt  = col_r;
      olast_nxt = (sel == 2'd3);
      odone_nxt = (sel == 2'd3) && ends;
      if (!emitting_r) begin
        emitting_nxt = 1'b1;
        phase_nxt    = 2'd1;
      end else if (phase_r == 2'd3) begin
        // Fourth pixel: commit the move and retire the step.
        emitting_nxt = 1'b0;
        phase_nxt    = 2'd0;
        ox_nxt       = x1[OW-1:0];
        oy_nxt       = y1[OW-1:0];
        d_nxt        = d1[DW-1:0];
        col_nxt      = col_r + CRG_COLOUR_STEP;
        active_nxt   = !ends;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      emitting_r <= 1'b0;
      phase_r    <= 2'd0;
      ov_r       <= 1'b0;
      ox_r       <= '0;
      oy_r       <= '0;
      d_r        <= '0;
      cx_r       <= '0;
      cy_r       <= '0;
      col_r      <= '0;
    end else begin
      active_r   <= active_nxt;
      emitting_r <= emitting_nxt;
      phase_r    <= phase_nxt;
      ov_r       <= ov_nxt;
      ox_r       <= ox_nxt;
      oy_r       <= oy_nxt;
      d_r        <= d_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      col_r      <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opx_r   <= opx_nxt;
    opy_r   <= opy_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign pix_valid       = ov_r;
  assign pix_x           = opx_r;
  assign pix_y           = opy_r;
  assign pix_colour      = ocol_r;
  assign pix_last        = olast_r;
  assign pix_done        = odone_r;
  assign status.active   = active_r;
  assign status.emitting = emitting_r;

endmodule

@@ src/circle_raster_generator_unit.sv @@
// ---------------------------------------------------------------------------
// circle_raster_generator_unit
// Bresenham circle rasterizer with four-way symmetric pixel output.
// ---------------------------------------------------------------------------
// Usage: send a start item (in_tuser = 0) carrying the centre, radius and
// colour; it loads the circle and produces no output. Each step item
// (in_tuser = 1) produces four pixel items on the out_ channel, in the order
// (+x,+y), (+x,-y), (-x,+y), (-x,-y) around the centre. out_tlast marks the
// fourth pixel of a step and out_tuser marks the final pixel of the circle.
// A step sent while no circle is in progress is dropped silently.
// Throughput: a step occupies the pixel engine for its four pixels, one per
// cycle through its single output register while out_tready is high; a start
// only loads the circle; each item passes the input register and the queue.
// The input register and a four-entry command queue decouple the two sides,
// so the block keeps accepting items while pixels wait on the receiver.
// When out_tready is low the output register holds its pixel, the engine
// stalls and, once the queue fills, in_tready drops.
// Reset (synchronous, active low) clears the queue and ends any circle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_raster_generator_unit
  import crg_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CRG_COORD_WIDTH,
  parameter int unsigned QUEUE_DEPTH = CRG_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  // tdata: center_x, center_y, radius, start_colour (lowest bits first)
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((3 * COORD_WIDTH + 31) + 7) / 8 * 8 - 1:0] in_tdata,
  // tuser: operation (0 = start circle, 1 = step)
  input  logic                                         in_tuser,
  // tdata: pixel_x, pixel_y, pixel_colour (lowest bits first)
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [((2 * COORD_WIDTH + 36) + 7) / 8 * 8 - 1:0] out_tdata,
  // tlast: last pixel of the step
  output logic                                         out_tlast,
  // tuser: done_res, final pixel of the circle
  output logic                                         out_tuser
);

  localparam int unsigned IN_DATA_W  = ((3 * COORD_WIDTH + 31) + 7) / 8 * 8;
  localparam int unsigned OUT_DATA_W = ((2 * COORD_WIDTH + 36) + 7) / 8 * 8;
  localparam int unsigned OUT_USED_W = 2 * COORD_WIDTH + 36;
  localparam int unsigned CMD_W      = 3 * COORD_WIDTH + 32;
  localparam int unsigned LVL_W      = $clog2(QUEUE_DEPTH + 1);

  logic                          f_valid, f_ready;
  logic [CMD_W-1:0]              f_data;
  logic                          q_valid, q_ready;
  logic [CMD_W-1:0]              q_data;
  logic [LVL_W-1:0]              q_level;
  logic signed [COORD_WIDTH+1:0] pix_x, pix_y;
  logic [31:0]                   pix_colour;
  back_status_t                  back_status;

  // Front: register the incoming item and tag it as start or step.
  crg_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .IN_DATA_W   (IN_DATA_W),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  // Queue: absorbs items while the engine works through a step.
  crg_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data),
    .level    (q_level)
  );

  // Back: circle state, decision rule and the pixel output register.
  crg_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_data   (q_data),
    .pix_valid  (out_tvalid),
    .pix_ready  (out_tready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_colour (pix_colour),
    .pix_last   (out_tlast),
    .pix_done   (out_tuser),
    .status     (back_status)
  );

  assign out_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, pix_colour, pix_y, pix_x};

  // The circle only ends on the fourth pixel of a step.
  `ASSERT_IMPLIES(a_done_on_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  // Pixels of a step are only produced while a circle is loaded.
  `ASSERT_IMPLIES(a_emit_needs_active, clk, rst_n, back_status.emitting, back_status.active)
  // The queue never holds more than its depth.
  `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_level <= LVL_W'(QUEUE_DEPTH))
  // A full queue must push back on the front stage.
  `ASSERT_IMPLIES(a_full_blocks, clk, rst_n, q_level == LVL_W'(QUEUE_DEPTH), !f_ready)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the circle raster generator: a queued stream of
// start and step items drives the block, a behavioral tracer predicts every
// pixel, and a monitor compares each pixel item with the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
  import crg_pkg::*;

  localparam int unsigned CW = CRG_COORD_WIDTH;
  localparam int unsigned IN_W = ((3 * CW + 31) + 7) / 8 * 8;
  localparam int unsigned OUT_W = ((2 * CW + 36) + 7) / 8 * 8;
  localparam int unsigned PW = CW + 2;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER = 100;

  // One queued input item; a pause entry makes the sender wait until
  // every predicted pixel has come back.
  typedef struct {
    logic              pause;
    cmd_kind_t         kind;
    logic [CW-1:0]     cx;
    logic [CW-1:0]     cy;
    logic [CW-2:0]     radius;
    logic [31:0]       colour;
  } circle_cmd_t;

  typedef struct {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [31:0]   colour;
    logic          last;
    logic          done;
  } pixel_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic             out_tuser;

  circle_cmd_t cmd_q[$];
  pixel_t      pixel_q[$];
  int          mismatches;
  int          pixels_seen;
  int          idle_cycles;

  // Tracer state: the circle as the block should currently hold it.
  int          trc_x, trc_y, trc_d, trc_cx, trc_cy;
  logic [31:0] trc_colour;
  logic        trc_active;

  circle_raster_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // One move of the midpoint rule: right, down or diagonal.
  function automatic void move_point(inout int x, inout int y, inout int d);
    int x0, y0, d0;
    x0 = x;
    y0 = y;
    d0 = d;
    if (d0 < 0 && 2 * (d0 + y0) - 1 <= 0) begin
      x = x0 + 1;
      d = d0 + 2 * x + 1;
    end else if (d0 > 0 && 2 * (d0 - x0) - 1 > 0) begin
      y = y0 - 1;
      d = d0 + 1 - 2 * y;
    end else begin
      x = x0 + 1;
      d = d0 + 2 * (x - y0);
      y = y0 - 1;
    end
  endfunction

  // Number of step items that it takes to close a circle of radius r.
  function automatic int steps_to_close(int r);
    int x, y, d, n;
    x = 0;
    y = r;
    d = 1 - 2 * r;
    n = 0;
    do begin
      move_point(x, y, d);
      n++;
    end while (y >= 0);
    return n;
  endfunction

  // Applies one accepted item to the tracer and queues the pixels it yields.
  task automatic trace_item(input logic op, input logic [IN_W-1:0] data);
    pixel_t p;
    int     x, y;
    logic   ends;
    if (cmd_kind_t'(op) == CMD_START) begin
      trc_cx     = int'(data[CW-1:0]);
      trc_cy     = int'(data[2*CW-1:CW]);
      trc_x      = 0;
      trc_y      = int'(data[3*CW-2:2*CW]);
      trc_d      = 1 - 2 * trc_y;
      trc_colour = data[3*CW+30:3*CW-1];
      trc_active = 1'b1;
    end else if (trc_active) begin
      x = trc_x;
      y = trc_y;
      move_point(trc_x, trc_y, trc_d);
      ends = (trc_y < 0);
      p.colour = trc_colour;
      for (int k = 0; k < 4; k++) begin
        p.px   = PW'((k < 2) ? trc_cx + x : trc_cx - x);
        p.py   = PW'((k % 2 == 0) ? trc_cy + y : trc_cy - y);
        p.last = (k == 3);
        p.done = (k == 3) && ends;
        pixel_q.push_back(p);
      end
      trc_colour = trc_colour + CRG_COLOUR_STEP;
      if (ends) trc_active = 1'b0;
    end
  endtask

  function automatic circle_cmd_t start_cmd(logic [CW-1:0] cx, logic [CW-1:0] cy,
                                            logic [CW-2:0] r, logic [31:0] colour);
    circle_cmd_t c;
    c.pause  = 1'b0;
    c.kind   = CMD_START;
    c.cx     = cx;
    c.cy     = cy;
    c.radius = r;
    c.colour = colour;
    return c;
  endfunction

  // Step items carry random payload bits, which the block must ignore.
  function automatic circle_cmd_t step_cmd();
    circle_cmd_t c;
    c = start_cmd(CW'($urandom), CW'($urandom), (CW-1)'($urandom), $urandom);
    c.kind = CMD_STEP;
    return c;
  endfunction

  task automatic push_steps(int n);
    for (int i = 0; i < n; i++) cmd_q.push_back(step_cmd());
  endtask

  // Sender: bursts of random length with random gaps in between. A pause
  // entry at the head of the queue holds it off until all pixels are back.
  int burst_left = 1;
  int gap_left   = 0;
  always @(posedge clk) begin
    circle_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) trace_item(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0 && cmd_q[0].pause) begin
          in_tvalid <= 1'b0;
          if (pixel_q.size() == 0) void'(cmd_q.pop_front());
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= c.kind;
          in_tdata  <= IN_W'({c.colour, c.radius, c.cy, c.cx});
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each pixel item and stalls on its own pattern. Once,
  // after enough pixels, it holds off for a long stretch so that the block
  // fills up and drops in_tready.
  int  ready_mode  = 0;
  int  mode_left   = 0;
  int  hold_left   = 0;
  bit  held_once   = 0;
  always @(posedge clk) begin
    pixel_t e;
    logic   rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected pixel x=%0d y=%0d colour=%h",
                     $signed(out_tdata[PW-1:0]), $signed(out_tdata[2*PW-1:PW]),
                     out_tdata[2*PW+31:2*PW]);
        end else begin
          e = pixel_q.pop_front();
          if (out_tdata[PW-1:0] !== e.px || out_tdata[2*PW-1:PW] !== e.py ||
              out_tdata[2*PW+31:2*PW] !== e.colour || out_tlast !== e.last ||
              out_tuser !== e.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: pixel %0d expected x=%0d y=%0d colour=%h last=%b ",
                        "done=%b, got x=%0d y=%0d colour=%h last=%b done=%b"},
                       pixels_seen, $signed(e.px), $signed(e.py), e.colour, e.last,
                       e.done, $signed(out_tdata[PW-1:0]),
                       $signed(out_tdata[2*PW-1:PW]), out_tdata[2*PW+31:2*PW],
                       out_tlast, out_tuser);
          end
        end
      end
      if (mode_left <= 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      case (ready_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ($urandom_range(0, 7) != 0);
      endcase
      if (!held_once && pixels_seen >= HOLD_AFTER) begin
        held_once = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // Watchdog: too many cycles with no item accepted on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int counted, r, n;
    mismatches  = 0;
    pixels_seen = 0;
    idle_cycles = 0;
    trc_x = 0; trc_y = 0; trc_d = 0; trc_cx = 0; trc_cy = 0;
    trc_colour = '0;
    trc_active = 1'b0;
    rst_n = 1'b0;

    // Directed part. A step right after reset finds no circle and is dropped.
    cmd_q.push_back(step_cmd());
    // Radius zero at the origin: the centre four times, then done.
    cmd_q.push_back(start_cmd('0, '0, '0, 32'hFFFF_FFFF));
    push_steps(2);
    // Largest radius at the far corner, abandoned by a new start.
    cmd_q.push_back(start_cmd('1, '1, '1, 32'h0000_0000));
    push_steps(4);
    cmd_q.push_back(start_cmd('1, '0, (CW-1)'(1), 32'h0000_FFFF));
    push_steps(steps_to_close(1) + 1);
    cmd_q.push_back(start_cmd('0, '1, (CW-1)'(3), 32'h0001_0000));
    push_steps(steps_to_close(3));
    cmd_q.push_back(start_cmd(CW'($urandom), CW'($urandom), '0, $urandom));
    cmd_q.push_back('{pause: 1'b1, kind: CMD_STEP, default: '0});

    // Random part: mostly complete circles of small radius, with abandoned
    // circles, stray steps and occasional pauses mixed in.
    counted = 0;
    while (counted < 80) begin
      case ($urandom_range(0, 9))
        0: push_steps(1);
        1: begin
          cmd_q.push_back(start_cmd(CW'($urandom), CW'($urandom), (CW-1)'($urandom),
                                    $urandom));
          n = $urandom_range(0, 6);
          push_steps(n);
          counted += n + 1;
        end
        default: begin
          r = $urandom_range(0, 12);
          n = steps_to_close(r);
          if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
          cmd_q.push_back(start_cmd(CW'($urandom), CW'($urandom), (CW-1)'(r), $urandom));
          push_steps(n + $urandom_range(0, 1));
          counted += n + 1;
        end
      endcase
      if (counted >= 50 && counted < 70 && $urandom_range(0, 2) == 0)
        cmd_q.push_back('{pause: 1'b1, kind: CMD_STEP, default: '0});
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge so that the sender's updates have settled.
    while (cmd_q.size() > 0 || in_tvalid || pixel_q.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/crg_pkg.sv
src/crg_front.sv
src/crg_queue.sv
src/crg_back.sv
src/circle_raster_generator_unit.sv
sim/tb.sv
